>>> rtl/core/wpa_pkg.sv
// shared types, constants and the quarter-sine table builder for the phase-to-amplitude block
`default_nettype none

package wpa_pkg;

    // defaults for the top-level parameters
    localparam int DEF_TABLE_ENTRIES = 257;
    localparam int DEF_PHASE_BITS    = 16;

    // fixed widths of the payload and the configuration register
    localparam int AMP_W  = 16;
    localparam int WAVE_W = 2;
    localparam int ROM_W  = 15;

    // full scale in Q1.15 and the triangle's quarter span
    localparam logic signed [AMP_W-1:0] FULL_SCALE  = 16'sd32767;
    localparam logic signed [AMP_W:0]   QUARTER_Q15 = 17'sd32768;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // shape select codes
    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2
    } t_waveform;

    // one quarter-sine word from the taylor sum in Q30: clamp at zero, round, clamp at full scale
    function automatic logic [ROM_W-1:0] rom_word_of_sum(input longint sum);
        longint unsigned mag;
        longint unsigned v;
        mag = (sum > 0) ? unsigned'(sum) : 64'd0;
        v   = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wpa_sine_rom.sv
// quarter-sine rom with one registered read port, contents built at elaboration
`default_nettype none

module wpa_sine_rom #(
    parameter int TABLE_ENTRIES = wpa_pkg::DEF_TABLE_ENTRIES,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [IDX_W-1:0]            i_addr,
    output logic      [wpa_pkg::ROM_W-1:0]   o_data
);

    localparam longint unsigned LAST = longint'(TABLE_ENTRIES - 1);

    logic [wpa_pkg::ROM_W-1:0] rom_words [TABLE_ENTRIES];
    logic [wpa_pkg::ROM_W-1:0] r_data;

    // one constant word per entry, angle = (pi/2)*i/last rounded in q30
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_word
        localparam longint unsigned X_Q30 =
            (wpa_pkg::HALF_PI_Q30 * longint'(g) + LAST / 2) / LAST;
        // taylor terms, each truncated: two multiplies by the angle, then the factorial step
        localparam longint unsigned T1 = ((((X_Q30 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd6;
        localparam longint unsigned T2 = ((((T1 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd20;
        localparam longint unsigned T3 = ((((T2 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd42;
        localparam longint unsigned T4 = ((((T3 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd72;
        localparam longint unsigned T5 = ((((T4 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd110;
        localparam longint unsigned T6 = ((((T5 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd156;
        localparam longint unsigned T7 = ((((T6 * X_Q30) >> 30) * X_Q30) >> 30) / 64'd210;
        localparam longint SUM = longint'(X_Q30) - longint'(T1) + longint'(T2)
                                 - longint'(T3) + longint'(T4) - longint'(T5)
                                 + longint'(T6) - longint'(T7);
        assign rom_words[g] = wpa_pkg::rom_word_of_sum(SUM);
    end

    // registered read, held while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_words[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> rtl/core/waveform_phase_to_amplitude.sv
// top level of the oscillator phase-to-amplitude converter: sine, triangle, square
//
// input channel: i_valid / o_stall with i_phase; a beat is taken at a rising edge
// with i_valid high and o_stall low. only the low PHASE_BITS bits form the phase.
// output channel: o_valid / i_stall with o_amplitude, signed Q1.15 in -32767..32767.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_waveform (0 sine, 1 triangle,
// 2 square, 3 gives zero); always ready, and it must be written only while the block
// is idle, which the block itself does not enforce. a beat passes from the registered
// read of the quarter-sine rom to the stage that forms the sign and picks the shape
// into the output register. throughput: one beat per cycle, sustained as long as
// i_stall stays low. when the receiver stalls, the output register holds its beat and
// the rom stage keeps taking beats until it is full too; only then is o_stall raised.
// reset (synchronous, active low) empties both stages and selects sine; the rom
// contents are constants and need no clearing pass.
`default_nettype none

module waveform_phase_to_amplitude #(
    parameter int TABLE_ENTRIES = wpa_pkg::DEF_TABLE_ENTRIES,
    parameter int PHASE_BITS    = wpa_pkg::DEF_PHASE_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // phase in
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic        [PHASE_BITS-1:0]          i_phase,
    // amplitude out
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed      [wpa_pkg::AMP_W-1:0]      o_amplitude,
    // waveform register write
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [wpa_pkg::WAVE_W-1:0]     i_cfg_waveform
);

    localparam int WB     = PHASE_BITS - 2;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int PROD_W = PHASE_BITS + IDX_W;
    localparam int SHR    = (WB >= 15) ? WB - 15 : 0;
    localparam int SHL    = (WB < 15) ? 15 - WB : 0;
    localparam int EXT_W  = WB + 15;
    localparam int AW     = wpa_pkg::AMP_W;

    // configuration register
    wpa_pkg::t_waveform r_waveform;

    // rom stage
    logic                      r_s1_valid;
    logic                      r_s1_sine;
    logic                      r_s1_neg;
    logic signed [AW-1:0]      r_s1_alt;
    logic [wpa_pkg::ROM_W-1:0] rom_data;

    // output stage
    logic                      r_out_valid;
    logic signed [AW-1:0]      r_out_amp;
    logic signed [AW-1:0]      n_out_amp;

    // stage enables
    logic en_s1;
    logic en_out;

    // front-end decode
    logic [1:0]             quad;
    logic [WB-1:0]          pos;
    logic [PROD_W-1:0]      sin_prod;
    logic [IDX_W-1:0]       sin_idx;
    logic [IDX_W-1:0]       rom_addr;
    logic [EXT_W-1:0]       pos_ext;
    logic [14:0]            tri_v;
    logic signed [AW:0]     tri_raw;
    logic signed [AW-1:0]   n_alt;

    assign en_out  = !r_out_valid || !i_stall;
    assign en_s1   = !r_s1_valid || en_out;
    assign o_stall = !en_s1;

    assign o_cfg_ready = 1'b1;

    // waveform register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= wpa_pkg::WAVE_SINE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_waveform <= wpa_pkg::t_waveform'(i_cfg_waveform);
        end
    end

    // quarter and position within it
    assign quad = i_phase[PHASE_BITS-1 -: 2];
    assign pos  = i_phase[WB-1:0];

    // rom index: position scaled to the table, rounded half up, mirrored in odd quarters
    always_comb begin
        sin_prod = PROD_W'({pos, 1'b0}) * PROD_W'(TABLE_ENTRIES - 1)
                   + (PROD_W'(1) << WB);
        sin_idx  = sin_prod[PHASE_BITS-1 +: IDX_W];
        rom_addr = quad[0] ? (IDX_W'(TABLE_ENTRIES - 1) - sin_idx) : sin_idx;
    end

    // triangle: position in q15, piecewise by quarter, then saturate
    always_comb begin
        pos_ext = EXT_W'(pos);
        tri_v   = 15'((pos_ext << SHL) >> SHR);
        case (quad)
            2'd0:    tri_raw = (AW+1)'(signed'({2'b00, tri_v}));
            2'd1:    tri_raw = wpa_pkg::QUARTER_Q15 - (AW+1)'(signed'({2'b00, tri_v}));
            2'd2:    tri_raw = -(AW+1)'(signed'({2'b00, tri_v}));
            default: tri_raw = (AW+1)'(signed'({2'b00, tri_v})) - wpa_pkg::QUARTER_Q15;
        endcase
    end

    // non-sine value, chosen ahead of the rom read
    always_comb begin
        unique case (r_waveform)
            wpa_pkg::WAVE_TRIANGLE: begin
                if (tri_raw > (AW+1)'(wpa_pkg::FULL_SCALE)) begin
                    n_alt = wpa_pkg::FULL_SCALE;
                end else if (tri_raw < -(AW+1)'(wpa_pkg::FULL_SCALE)) begin
                    n_alt = -wpa_pkg::FULL_SCALE;
                end else begin
                    n_alt = tri_raw[AW-1:0];
                end
            end
            wpa_pkg::WAVE_SQUARE: begin
                n_alt = quad[1] ? -wpa_pkg::FULL_SCALE : wpa_pkg::FULL_SCALE;
            end
            default: begin
                n_alt = '0;
            end
        endcase
    end

    // quarter-sine table with registered read
    wpa_sine_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (en_s1),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // rom stage control and side payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_sine <= (r_waveform == wpa_pkg::WAVE_SINE);
            r_s1_neg  <= quad[1];
            r_s1_alt  <= n_alt;
        end
    end

    // sign the rom word or pass the other shape
    always_comb begin
        if (r_s1_sine) begin
            n_out_amp = r_s1_neg ? -AW'(signed'({1'b0, rom_data}))
                                 :  AW'(signed'({1'b0, rom_data}));
        end else begin
            n_out_amp = r_s1_alt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1_valid) begin
            r_out_amp <= n_out_amp;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_amplitude = r_out_amp;

    // the most negative code never leaves the block
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_amplitude != -16'sd32768))
        else $error("amplitude reached the most negative code");

    // stall is raised only with both stages full and the receiver stalling
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted beat lands in the rom stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted beat lost at the rom stage");

    // a beat waiting in the rom stage is never dropped while the output is stalled
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |=> (r_s1_valid && $stable(rom_data)))
        else $error("rom stage beat changed under stall");

endmodule

`default_nettype wire
